[sv/etok_pkg.sv]
// ============================================================================
// etok_pkg
// Shared types, codes and constants of the expression tokenizer.
// ============================================================================
package etok_pkg;

    // Parameter defaults
    localparam int MAX_FRAC_DIGITS_DEF = 9;
    localparam int INT_BITS_DEF        = 16;

    // Field widths
    localparam int CH_W     = 8;
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int SYMBOL_W = 8;
    localparam int FCNT_W   = 4;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_NUM   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INVAL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd5;

    // Characters
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CH_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CH_W-1:0] CH_R     = 8'h52;
    localparam logic [CH_W-1:0] CH_L     = 8'h4C;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CH_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    // Fraction accumulator: guard bits below the value LSB. Each digit weight
    // is truncated, so the sum runs low by less than 81 guard LSBs; rounding
    // adds half an LSB plus a slack that covers this but stays far below the
    // smallest gap between a decimal fraction of 9 digits and a half LSB.
    localparam int GUARD_W     = 40;
    localparam int ROUND_SLACK = 128;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  value;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } token_t;

endpackage

[sv/expression_tokenizer_unit.sv]
// ============================================================================
// expression_tokenizer_unit
// Byte-stream tokenizer for arithmetic expressions with fixed-point numbers.
// ============================================================================
// Usage:
//   Feed one expression byte per request on the s_axis channel; tlast (or a
//   zero byte) ends the expression. Tokens leave on m_axis: tuser is the kind,
//   tdata carries the Q(INT_BITS).(32-INT_BITS) value and the symbol byte,
//   tlast marks the last token caused by one input request.
// Numbers: the integer part and a binary fraction are built digit by digit,
//   so the value is ready when the byte that ends the number arrives.
// Output: the tokens of a request are written into the output queue at the
//   edge that accepts the request and leave on m_axis from the queue head.
// Throughput: one input request per cycle while s_axis_tready is high and
//   one token per cycle out while m_axis_tready is high. A byte that closes
//   a number yields two tokens, so the output side paces such bytes.
// Reset: rst_n clears the scanner to idle with no number pending and empties
//   the output queue.
// Stall: when m_axis_tready is low the output queue holds; once fewer than
//   two free entries remain s_axis_tready drops and the scanner holds.
// ============================================================================
module expression_tokenizer_unit #(
    parameter int MAX_FRAC_DIGITS = etok_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int INT_BITS        = etok_pkg::INT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [etok_pkg::CH_W-1:0] s_axis_tdata,   // [7:0] ch
    input  logic                      s_axis_tlast,   // end_of_text
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [39:0]               m_axis_tdata,   // [31:0] value, [39:32] symbol
    output logic [etok_pkg::KIND_W-1:0] m_axis_tuser, // [2:0] kind
    output logic                      m_axis_tlast    // run_last
);
    import etok_pkg::*;

    localparam int FRAC_BITS = VALUE_W - INT_BITS;
    localparam int IPART_W   = INT_BITS + 1;
    localparam int IX10_W    = IPART_W + 4;
    localparam int ACC_W     = FRAC_BITS + GUARD_W;
    localparam int SUM_W     = VALUE_W + 1;
    localparam logic [IPART_W-1:0] INT_LIMIT = {1'b1, {INT_BITS{1'b0}}};
    localparam logic [FCNT_W-1:0]  FRAC_MAX  = FCNT_W'(MAX_FRAC_DIGITS);

    // Weight of the k-th fraction digit: 2^ACC_W / 10^k, truncated
    localparam logic [ACC_W:0]   ACC_ONE   = {1'b1, {ACC_W{1'b0}}};
    localparam logic [ACC_W-1:0] WEIGHT_1  = ACC_W'(ACC_ONE / 10);
    localparam logic [ACC_W-1:0] WEIGHT_2  = ACC_W'(ACC_ONE / 100);
    localparam logic [ACC_W-1:0] WEIGHT_3  = ACC_W'(ACC_ONE / 1000);
    localparam logic [ACC_W-1:0] WEIGHT_4  = ACC_W'(ACC_ONE / 10000);
    localparam logic [ACC_W-1:0] WEIGHT_5  = ACC_W'(ACC_ONE / 100000);
    localparam logic [ACC_W-1:0] WEIGHT_6  = ACC_W'(ACC_ONE / 1000000);
    localparam logic [ACC_W-1:0] WEIGHT_7  = ACC_W'(ACC_ONE / 10000000);
    localparam logic [ACC_W-1:0] WEIGHT_8  = ACC_W'(ACC_ONE / 100000000);
    localparam logic [ACC_W-1:0] WEIGHT_9  = ACC_W'(ACC_ONE / 1000000000);
    // Half a value LSB plus the slack for the truncated weights
    localparam logic [ACC_W:0]   ROUND_ADD = (ACC_ONE >> (FRAC_BITS + 1)) + ROUND_SLACK;

    // Scanner modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_INT   = 2'd1;
    localparam logic [1:0] MODE_POINT = 2'd2;
    localparam logic [1:0] MODE_FRAC  = 2'd3;

    // Scanner state
    logic [1:0]         mode_reg, mode_next;
    logic [IPART_W-1:0] ipart_reg, ipart_next;
    logic [ACC_W-1:0]   facc_reg, facc_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;

    // Output queue
    token_t             fifo_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // Front-end decode
    logic                 advance, accept;
    logic [CH_W-1:0]      ch;
    logic [3:0]           digit;
    logic                 is_end, is_skip, is_digit, is_point_int, is_other;
    logic                 emit_num, emit_tok;
    logic [KIND_W-1:0]    tok_kind;
    logic [SYMBOL_W-1:0]  tok_symbol;
    logic [IX10_W-1:0]    ipart_x10;
    logic [ACC_W-1:0]     weight, facc_term;
    logic                 frac_sat;

    // Number value
    logic [ACC_W:0]       frac_rnd;
    logic [FRAC_BITS:0]   frac_q;
    logic [SUM_W-1:0]     num_sum;
    logic [VALUE_W-1:0]   num_value;

    // Queue fill
    token_t num_tok, op_tok;
    logic   push_num, push_tok, pop;

    // Advance only while the queue can take both tokens of one item
    assign advance       = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    assign ch           = s_axis_tdata;
    assign digit        = ch[3:0];   // low nibble of '0'..'9' is the digit
    assign is_end       = s_axis_tlast || (ch == CH_NUL);
    assign is_skip      = !is_end && ((ch < CH_BANG) || (ch == CH_DEL));
    assign is_digit     = !is_end && (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_point_int = !is_end && (ch == CH_POINT) && (mode_reg == MODE_INT);
    assign is_other     = !is_end && !is_skip && !is_digit && !is_point_int;
    assign emit_tok     = is_end || is_other;
    assign emit_num     = emit_tok && (mode_reg != MODE_IDLE);

    always_comb
    begin
        tok_kind   = KIND_INVAL;
        tok_symbol = ch;
        if (is_end)
        begin
            tok_kind   = KIND_END;
            tok_symbol = '0;
        end
        else
        begin
            case (ch) inside
                CH_PLUS, CH_STAR, CH_TILDE, CH_SLASH, CH_CARET, CH_R, CH_L:
                begin
                    tok_kind = KIND_OPER;
                end
                CH_OPEN:
                begin
                    tok_kind   = KIND_OPEN;
                    tok_symbol = '0;
                end
                CH_CLOSE:
                begin
                    tok_kind   = KIND_CLOSE;
                    tok_symbol = '0;
                end
                default:
                begin
                    tok_kind = KIND_INVAL;
                end
            endcase
        end
    end

    // Accumulate one integer digit: ipart * 10 + d
    assign ipart_x10 = ({4'd0, ipart_reg} << 3) + ({4'd0, ipart_reg} << 1)
                     + IX10_W'(digit);
    // An integer part at the limit saturates the number
    assign frac_sat  = ipart_reg[INT_BITS];

    // Weight of the next fraction digit
    always_comb
    begin
        case (fcnt_reg)
            4'd0:    weight = WEIGHT_1;
            4'd1:    weight = WEIGHT_2;
            4'd2:    weight = WEIGHT_3;
            4'd3:    weight = WEIGHT_4;
            4'd4:    weight = WEIGHT_5;
            4'd5:    weight = WEIGHT_6;
            4'd6:    weight = WEIGHT_7;
            4'd7:    weight = WEIGHT_8;
            4'd8:    weight = WEIGHT_9;
            default: weight = '0;
        endcase
    end

    // Digit times weight by shift and add
    assign facc_term = (digit[0] ? weight        : '0)
                     + (digit[1] ? (weight << 1) : '0)
                     + (digit[2] ? (weight << 2) : '0)
                     + (digit[3] ? (weight << 3) : '0);

    always_comb
    begin
        mode_next  = mode_reg;
        ipart_next = ipart_reg;
        facc_next  = facc_reg;
        fcnt_next  = fcnt_reg;
        if (accept)
        begin
            if (emit_tok)
            begin
                mode_next  = MODE_IDLE;
                ipart_next = '0;
                facc_next  = '0;
                fcnt_next  = '0;
            end
            else if (is_digit)
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        ipart_next = IPART_W'(digit);
                        facc_next  = '0;
                        fcnt_next  = '0;
                        mode_next  = MODE_INT;
                    end
                    MODE_INT:
                    begin
                        // Clamp an oversized integer part to the limit
                        if (ipart_x10 > IX10_W'(INT_LIMIT))
                        begin
                            ipart_next = INT_LIMIT;
                        end
                        else
                        begin
                            ipart_next = ipart_x10[IPART_W-1:0];
                        end
                    end
                    MODE_POINT, MODE_FRAC:
                    begin
                        // Drop digits past the limit or after saturation
                        if (!frac_sat && (fcnt_reg < FRAC_MAX))
                        begin
                            facc_next = facc_reg + facc_term;
                            fcnt_next = fcnt_reg + 1'b1;
                        end
                        mode_next = MODE_FRAC;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
            else if (is_point_int)
            begin
                mode_next = MODE_POINT;
            end
        end
    end

    // Round the fraction to nearest, then add the integer part
    assign frac_rnd  = {1'b0, facc_reg} + ROUND_ADD;
    assign frac_q    = frac_rnd[ACC_W:GUARD_W];
    assign num_sum   = (SUM_W'(ipart_reg[INT_BITS-1:0]) << FRAC_BITS) + SUM_W'(frac_q);
    assign num_value = (frac_sat || num_sum[VALUE_W]) ? {VALUE_W{1'b1}}
                                                      : num_sum[VALUE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            ipart_reg <= '0;
            facc_reg  <= '0;
            fcnt_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            ipart_reg <= ipart_next;
            facc_reg  <= facc_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    // Up to two queue entries per request, number first
    always_comb
    begin
        num_tok.kind   = KIND_NUM;
        num_tok.value  = num_value;
        num_tok.symbol = '0;
        num_tok.last   = 1'b0;
        op_tok.kind    = tok_kind;
        op_tok.value   = '0;
        op_tok.symbol  = tok_symbol;
        op_tok.last    = 1'b1;
    end

    assign push_num = accept && emit_num;
    assign push_tok = accept && emit_tok;
    assign pop      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push_num)
        begin
            fifo_reg[wr_ptr_reg] <= num_tok;
        end
        if (push_tok)
        begin
            if (push_num)
            begin
                fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= op_tok;
            end
            else
            begin
                fifo_reg[wr_ptr_reg] <= op_tok;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_num) + FIFO_AW'(push_tok);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_num) + FIFO_CW'(push_tok)
                    - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Present the queue head
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {fifo_reg[rd_ptr_reg].symbol, fifo_reg[rd_ptr_reg].value};
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].kind;
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].last;

endmodule

[tb/tb_expression_tokenizer_unit.sv]
// ============================================================================
// tb_expression_tokenizer_unit
// Self-checking bench for the expression tokenizer.
// ============================================================================
// Bytes go in on the s_axis channel and tokens come out on m_axis. A
// scoreboard class runs its own scanner on every accepted request and
// queues the tokens it must produce. Each token taken from m_axis is then
// compared field by field with the oldest queued one.
// Stimulus has two parts. A short directed part covers every operator and
// bracket, invalid and skipped bytes, points in odd places, both ways of
// ending an expression and a number that rounds past full scale. A random
// part follows. Most of it is well-formed expressions whose numbers have
// random lengths, fractions and embedded blanks. The rest is raw byte
// noise. Both channels idle at random, except during one long stretch.
// ============================================================================
module tb_expression_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import etok_pkg::*;

    localparam int          ITEM_TARGET   = 1650;
    localparam int          INT_W         = INT_BITS_DEF;
    localparam int          FRAC_W        = VALUE_W - INT_W;
    localparam int          FRAC_LIMIT    = MAX_FRAC_DIGITS_DEF;
    localparam logic [63:0] INT_CEIL      = 64'd1 << INT_W;
    localparam logic [63:0] FULL_SCALE    = 64'hFFFF_FFFF;
    // Quiet time after the drain: a stray token would show up well within it.
    localparam int          SETTLE_CYCLES = 32;
    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          IDLE_PCT      = 15;
    localparam int          REPORT_MAX    = 10;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_POINT,
        SCAN_FRAC
    } scan_mode_e;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow scanner that turns requests into expected tokens
    // ------------------------------------------------------------------------
    class token_scoreboard;
        token_t      pending_tokens[$];
        scan_mode_e  mode;
        logic [63:0] mantissa;     // all digits so far, value = mantissa / 10^frac
        int unsigned frac_digits;
        int          requests;
        int          tokens;
        int          numbers;
        int          saturated;
        int          operators;
        int          invalids;
        int          errors;

        function new();
            mode        = SCAN_IDLE;
            mantissa    = '0;
            frac_digits = 0;
            requests    = 0;
            tokens      = 0;
            numbers     = 0;
            saturated   = 0;
            operators   = 0;
            invalids    = 0;
            errors      = 0;
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function void queue_token(input logic [KIND_W-1:0] kind,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [SYMBOL_W-1:0] symbol,
                                  input logic last);
            token_t t;
            t.kind   = kind;
            t.value  = value;
            t.symbol = symbol;
            t.last   = last;
            pending_tokens.push_back(t);
        endfunction

        // Emit the pending number, if any, as rounded fixed point.
        function void close_number();
            logic [63:0] divisor;
            logic [63:0] quotient;
            if (mode == SCAN_IDLE)
                return;
            divisor = 64'd1;
            for (int i = 0; i < frac_digits; i++)
                divisor = divisor * 10;
            // An integer part that hit the clamp saturates outright.
            if (frac_digits == 0 && mantissa >= INT_CEIL)
                quotient = FULL_SCALE;
            else
            begin
                quotient = ((mantissa << FRAC_W) + divisor / 2) / divisor;
                if (quotient > FULL_SCALE)
                    quotient = FULL_SCALE;
            end
            queue_token(KIND_NUM, quotient[VALUE_W-1:0], '0, 1'b0);
            mode        = SCAN_IDLE;
            mantissa    = '0;
            frac_digits = 0;
        endfunction

        function void note_request(input logic [CH_W-1:0] ch, input logic eot);
            logic [63:0] digit;
            requests++;
            // A zero byte ends the text just like tlast.
            if (eot || ch == CH_NUL)
            begin
                close_number();
                queue_token(KIND_END, '0, '0, 1'b1);
                return;
            end
            // Blanks and control bytes vanish, even in the middle of a number.
            if (ch < CH_BANG || ch == CH_DEL)
                return;
            if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                digit = 64'(ch - CH_ZERO);
                case (mode)
                    SCAN_IDLE:
                    begin
                        mantissa    = digit;
                        frac_digits = 0;
                        mode        = SCAN_INT;
                    end
                    SCAN_INT:
                    begin
                        mantissa = mantissa * 10 + digit;
                        if (mantissa > INT_CEIL)
                            mantissa = INT_CEIL;
                    end
                    default:
                    begin
                        // Drop fraction digits after an integer overflow or
                        // past the digit limit.
                        if (!(frac_digits == 0 && mantissa >= INT_CEIL) &&
                            frac_digits < FRAC_LIMIT)
                        begin
                            mantissa = mantissa * 10 + digit;
                            frac_digits++;
                        end
                        mode = SCAN_FRAC;
                    end
                endcase
                return;
            end
            if (ch == CH_POINT && mode == SCAN_INT)
            begin
                mode = SCAN_POINT;
                return;
            end
            // Anything else closes a number; a second point lands here too
            // and comes out as an invalid token.
            close_number();
            case (ch)
                CH_PLUS, CH_STAR, CH_TILDE, CH_SLASH, CH_CARET, CH_R, CH_L:
                    queue_token(KIND_OPER, '0, ch, 1'b1);
                CH_OPEN:  queue_token(KIND_OPEN, '0, '0, 1'b1);
                CH_CLOSE: queue_token(KIND_CLOSE, '0, '0, 1'b1);
                default:  queue_token(KIND_INVAL, '0, ch, 1'b1);
            endcase
        endfunction

        function void check_token(input token_t got);
            token_t want;
            tokens++;
            if (pending_tokens.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: token with none expected: kind %0d value %h symbol %h",
                             got.kind, got.value, got.symbol);
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.symbol !== want.symbol || got.last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("ERROR: token %0d: expected kind %0d value %h symbol %h last %b,",
                             tokens, want.kind, want.value, want.symbol, want.last);
                    $display("       got kind %0d value %h symbol %h last %b",
                             got.kind, got.value, got.symbol, got.last);
                end
            end
            case (want.kind)
                KIND_NUM:
                begin
                    numbers++;
                    if (want.value == FULL_SCALE[VALUE_W-1:0])
                        saturated++;
                end
                KIND_OPER:  operators++;
                KIND_INVAL: invalids++;
                default:    ;
            endcase
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CH_W-1:0]   s_axis_tdata  = '0;   // [7:0] ch
    logic              s_axis_tlast  = 1'b0; // end_of_text
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;         // [31:0] value, [39:32] symbol
    logic [KIND_W-1:0] m_axis_tuser;         // [2:0] kind
    logic              m_axis_tlast;         // run_last

    token_scoreboard   sb = new();
    token_t            seen_token;
    bit                steady_run   = 1'b0;  // no idling on either side
    int                items_sent   = 0;     // requests accepted so far
    logic [CH_W-1:0]   oper_chars [7] = '{CH_PLUS, CH_STAR, CH_TILDE, CH_SLASH,
                                          CH_CARET, CH_R, CH_L};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    expression_tokenizer_unit #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS_DEF),
        .INT_BITS        (INT_BITS_DEF)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stall the token side at random, except in the steady stretch.
    always @(posedge clk)
        m_axis_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);

    // Both handshakes are sampled on the edge that completes them. A token
    // can never belong to a request taken on the same edge, so the order of
    // the two calls does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_token.kind   = m_axis_tuser;
                seen_token.value  = m_axis_tdata[31:0];
                seen_token.symbol = m_axis_tdata[39:32];
                seen_token.last   = m_axis_tlast;
                sb.check_token(seen_token);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------------

    // Offer one byte, with random idle cycles first, and hold it until taken.
    task automatic send_byte(input logic [CH_W-1:0] ch, input logic eot);
        while (!steady_run && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Sometimes drop a blank, control byte or delete between characters.
    task automatic maybe_blank();
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(2))
                0:       send_byte(8'h20, 1'b0);
                1:       send_byte(8'($urandom_range(1, 31)), 1'b0);
                default: send_byte(CH_DEL, 1'b0);
            endcase
        end
    endtask

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_byte(8'(CH_ZERO + $urandom_range(9)), 1'b0);
            maybe_blank();
        end
    endtask

    task automatic send_number();
        int int_digits;
        int frac_len;
        // Now and then a value near full scale: rounding or clamping case.
        if ($urandom_range(19) == 0)
        begin
            if ($urandom_range(1) == 0)
                send_text("65535");
            else
                send_digits($urandom_range(5, 8));
            send_byte(CH_POINT, 1'b0);
            for (int i = 0; i < $urandom_range(8, 12); i++)
                send_byte(8'h39, 1'b0);
            return;
        end
        int_digits = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 3);
        send_digits(int_digits);
        if ($urandom_range(99) < 60)
        begin
            send_byte(CH_POINT, 1'b0);
            maybe_blank();
            frac_len = ($urandom_range(4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
            send_digits(frac_len);
            if ($urandom_range(19) == 0)
                send_byte(CH_POINT, 1'b0);
        end
    endtask

    // A well-formed expression with random content, then an end marker.
    task automatic send_expression();
        int terms;
        terms = $urandom_range(1, 6);
        for (int t = 0; t < terms; t++)
        begin
            if ($urandom_range(3) == 0)
                send_byte(CH_OPEN, 1'b0);
            if ($urandom_range(9) == 0)
                send_byte(8'($urandom_range(128, 255)), 1'b0);
            else
                send_number();
            maybe_blank();
            if ($urandom_range(4) == 0)
                send_byte(CH_CLOSE, 1'b0);
            if (t != terms - 1)
            begin
                send_byte(oper_chars[$urandom_range(6)], 1'b0);
                maybe_blank();
            end
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: send_byte(8'($urandom_range(255)), 1'b1);
            5:             send_byte(CH_NUL, 1'b1);
            default:       send_byte(CH_NUL, 1'b0);
        endcase
    endtask

    // Raw byte noise, with the odd tlast.
    task automatic send_noise();
        int count;
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
    endtask

    // Drop valid and hold until every queued token has arrived.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Open bracket, dangling point, second point, lone point, close,
        // every operator, an unknown symbol, then a high byte.
        send_text("(9.+1.2.~.)/^RL*-");
        send_byte(8'h80, 1'b0);
        // Skipped bytes must leave no trace, then a zero byte ends the text.
        send_byte(CH_DEL, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(CH_NUL, 1'b0);
        // Largest integer with excess nines: rounding passes full scale.
        send_text("65535.9999999999");
        send_byte(8'hFF, 1'b1);
        hold_until_drained();

        while (items_sent < ITEM_TARGET)
        begin
            steady_run = (items_sent >= 700 && items_sent < 950);
            // Pause the sender once mid-run until the block is empty.
            if (items_sent >= 1200 && !drained_mid)
            begin
                hold_until_drained();
                drained_mid = 1'b1;
            end
            if ($urandom_range(99) < 80)
                send_expression();
            else
                send_noise();
        end
        steady_run = 1'b0;

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d tokens: %0d numbers (%0d at full scale),",
                 sb.requests, sb.tokens, sb.numbers, sb.saturated);
        $display("%0d operators, %0d invalid bytes, %0d mismatches.",
                 sb.operators, sb.invalids, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(LIMIT_CYCLES * 12ns);
        $display("Timeout with %0d tokens outstanding", sb.pending());
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
sv/etok_pkg.sv
sv/expression_tokenizer_unit.sv
tb/tb_expression_tokenizer_unit.sv
